// File: hw/rtl/nbbr_pkg.sv
`timescale 1ns / 1ps

package nbbr_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_QUERY     = 2'd0;
    localparam logic [1:0] OP_WR_BITMAP = 2'd1;
    localparam logic [1:0] OP_WR_SUBST  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_PASS  = 3'd0;
    localparam logic [2:0] ST_SUBST = 3'd1;
    localparam logic [2:0] ST_NOSUB = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    // Configuration register indexes
    localparam logic CFG_CE_COUNT  = 1'b0;
    localparam logic CFG_SUB_COUNT = 1'b1;

    // Field widths fixed by the interface
    localparam int CHIP_W  = 8;
    localparam int BLOCK_W = 24;
    localparam int VB_W    = 33;
    localparam int LOC_W   = 32;
    localparam int IDX_W   = 7;
    localparam int STAT_W  = 3;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_query;
        logic              write_bm;
        logic              write_tab;
        logic              add;
        logic              check;
        logic              search_step;
        logic              finish;
        logic [STAT_W-1:0] fin_code;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic range_err;
        logic pass;
        logic match;
        logic exhausted;
    } t_sts;

endpackage

// File: hw/rtl/nbbr_ram.sv
`timescale 1ns / 1ps

module nbbr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nbbr_ctrl.sv
`timescale 1ns / 1ps

module nbbr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_operation,
    input  nbbr_pkg::t_sts      i_sts,
    output nbbr_pkg::t_cmd      o_cmd,
    output logic                busy,
    output logic                o_strobe
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_BIT  = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic           r_strobe;
    logic           accept;
    nbbr_pkg::t_cmd cmd;

    assign accept = start && (r_state == S_IDLE);

    // Sequence the query and issue datapath commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == nbbr_pkg::OP_QUERY) begin
                        cmd.load_query = 1'b1;
                        n_state        = S_ADD;
                    end else begin
                        cmd.write_bm  = (i_operation == nbbr_pkg::OP_WR_BITMAP);
                        cmd.write_tab = (i_operation == nbbr_pkg::OP_WR_SUBST);
                        cmd.finish    = 1'b1;
                        cmd.fin_code  = nbbr_pkg::ST_WRITE;
                    end
                end
            end
            S_ADD: begin
                cmd.add = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.range_err) begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = nbbr_pkg::ST_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    cmd.check = 1'b1;
                    n_state   = S_BIT;
                end
            end
            S_BIT: begin
                if (i_sts.pass) begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = nbbr_pkg::ST_PASS;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                cmd.search_step = 1'b1;
                if (i_sts.match) begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = nbbr_pkg::ST_SUBST;
                    n_state      = S_IDLE;
                end else if (i_sts.exhausted) begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = nbbr_pkg::ST_NOSUB;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state and mark the result cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= cmd.finish;
        end
    end

    assign o_cmd    = cmd;
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    // A query keeps the block busy and gives no result in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == nbbr_pkg::OP_QUERY) |=> (busy && !o_strobe))
        else $error("query did not hold the block busy");

    // A write answers in the next cycle and leaves the block free
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation != nbbr_pkg::OP_QUERY) |=> (o_strobe && !busy))
        else $error("write not answered in one cycle");

    // A result is shown only once the controller is back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

endmodule

// File: hw/rtl/nbbr_dp.sv
`timescale 1ns / 1ps

module nbbr_dp #(
    parameter int SUB_ENTRIES  = 64,
    parameter int BITMAP_BYTES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    input  logic [nbbr_pkg::CHIP_W-1:0]   i_chip,
    input  logic [nbbr_pkg::BLOCK_W-1:0]  i_block,
    input  logic                          i_pool_partition,
    input  logic [nbbr_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [7:0]                    i_bitmap_byte,
    input  logic [nbbr_pkg::LOC_W-1:0]    i_original_vblock,
    input  logic [nbbr_pkg::LOC_W-1:0]    i_spare_location,
    input  nbbr_pkg::t_cmd                i_cmd,
    output nbbr_pkg::t_sts                o_sts,
    output logic [nbbr_pkg::CHIP_W-1:0]   o_real_chip,
    output logic [nbbr_pkg::BLOCK_W-1:0]  o_real_block,
    output logic [nbbr_pkg::STAT_W-1:0]   o_status
);

    // Only indexes below 2**IDX_W can be written, so storage stops there
    localparam int IDX_SPAN = 1 << nbbr_pkg::IDX_W;
    localparam int BM_DEPTH = (BITMAP_BYTES < IDX_SPAN) ? BITMAP_BYTES : IDX_SPAN;
    localparam int TB_DEPTH = (SUB_ENTRIES < IDX_SPAN) ? SUB_ENTRIES : IDX_SPAN;
    localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
    localparam int TB_AW    = (TB_DEPTH > 1) ? $clog2(TB_DEPTH) : 1;
    localparam int CNT_W    = nbbr_pkg::IDX_W;
    localparam int BYTE_W   = nbbr_pkg::VB_W - 3;
    localparam int LIM_MAX  = (SUB_ENTRIES < IDX_SPAN - 1) ? SUB_ENTRIES : IDX_SPAN - 1;
    localparam int TAB_W    = 2 * nbbr_pkg::LOC_W;

    localparam logic [CNT_W-1:0]  LIMIT_MAX  = CNT_W'(LIM_MAX);
    localparam logic [BYTE_W-1:0] BYTE_LIMIT = BYTE_W'(BITMAP_BYTES);
    localparam logic [BYTE_W-1:0] BYTE_STORE = BYTE_W'(BM_DEPTH);

    // Configuration registers
    logic [7:0]       r_ce_count;
    logic [CNT_W-1:0] r_sub_count;

    // Query registers
    logic [nbbr_pkg::CHIP_W-1:0]  r_chip;
    logic [nbbr_pkg::BLOCK_W-1:0] r_block;
    logic                         r_pool;
    logic [nbbr_pkg::LOC_W-1:0]   r_prod;
    logic [nbbr_pkg::VB_W-1:0]    r_vb;
    logic                         r_bm_ok;
    logic [BM_DEPTH-1:0]          r_bm_vld;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_cmp_vld;

    // Result registers
    logic [nbbr_pkg::CHIP_W-1:0]  r_real_chip;
    logic [nbbr_pkg::BLOCK_W-1:0] r_real_block;
    logic [nbbr_pkg::STAT_W-1:0]  r_status;

    logic [BYTE_W-1:0]            byte_idx;
    logic [BM_AW-1:0]             bm_addr;
    logic                         bm_in_store;
    logic                         bm_we;
    logic                         tb_we;
    logic [7:0]                   bm_rdata;
    logic [TAB_W-1:0]             tb_rdata;
    logic [CNT_W-1:0]             limit;
    logic                         bad;

    assign byte_idx    = r_vb[nbbr_pkg::VB_W-1:3];
    assign bm_addr     = byte_idx[BM_AW-1:0];
    assign bm_in_store = (byte_idx < BYTE_STORE);
    assign bm_we       = i_cmd.write_bm && (32'(i_entry_index) < 32'(BM_DEPTH));
    assign tb_we       = i_cmd.write_tab && (32'(i_entry_index) < 32'(TB_DEPTH));
    assign limit       = (r_sub_count > LIMIT_MAX) ? LIMIT_MAX : r_sub_count;
    assign bad         = r_bm_ok && bm_rdata[r_vb[2:0]];

    nbbr_ram #(
        .WIDTH (8),
        .DEPTH (BM_DEPTH),
        .ADDR_W(BM_AW)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (bm_we),
        .i_waddr(i_entry_index[BM_AW-1:0]),
        .i_wdata(i_bitmap_byte),
        .i_raddr(bm_addr),
        .o_rdata(bm_rdata)
    );

    nbbr_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TB_DEPTH),
        .ADDR_W(TB_AW)
    ) u_subst (
        .i_clk  (i_clk),
        .i_we   (tb_we),
        .i_waddr(i_entry_index[TB_AW-1:0]),
        .i_wdata({i_original_vblock, i_spare_location}),
        .i_raddr(r_idx[TB_AW-1:0]),
        .o_rdata(tb_rdata)
    );

    // Status to the controller
    assign o_sts.range_err = (byte_idx >= BYTE_LIMIT);
    assign o_sts.pass      = !bad && !r_pool;
    assign o_sts.match     = r_cmp_vld
                             && ({1'b0, tb_rdata[TAB_W-1:nbbr_pkg::LOC_W]} == r_vb);
    assign o_sts.exhausted = !r_cmp_vld && (r_idx >= limit);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ce_count  <= 8'd1;
            r_sub_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nbbr_pkg::CFG_CE_COUNT:  r_ce_count  <= i_cfg_data;
                nbbr_pkg::CFG_SUB_COUNT: r_sub_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Mark bitmap bytes written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bm_vld <= '0;
        end else if (bm_we) begin
            r_bm_vld[i_entry_index[BM_AW-1:0]] <= 1'b1;
        end
    end

    // Search counter and compare qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.search_step && (r_idx < limit);
            if (i_cmd.check) begin
                r_idx <= '0;
            end else if (i_cmd.search_step && (r_idx < limit)) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Capture the query, form the virtual block, sample the bitmap bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_chip  <= i_chip;
            r_block <= i_block;
            r_pool  <= i_pool_partition;
            r_prod  <= {8'd0, i_block} * {24'd0, r_ce_count};
        end
        if (i_cmd.add) begin
            r_vb <= {1'b0, r_prod} + nbbr_pkg::VB_W'(r_chip);
        end
        if (i_cmd.check) begin
            r_bm_ok <= bm_in_store && r_bm_vld[bm_addr];
        end
    end

    // Load the result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.fin_code;
            case (i_cmd.fin_code)
                nbbr_pkg::ST_PASS: begin
                    r_real_chip  <= r_chip;
                    r_real_block <= r_block;
                end
                nbbr_pkg::ST_SUBST: begin
                    r_real_chip  <= tb_rdata[nbbr_pkg::LOC_W-1:nbbr_pkg::BLOCK_W];
                    r_real_block <= tb_rdata[nbbr_pkg::BLOCK_W-1:0];
                end
                default: begin
                    r_real_chip  <= '0;
                    r_real_block <= '0;
                end
            endcase
        end
    end

    assign o_real_chip  = r_real_chip;
    assign o_real_block = r_real_block;
    assign o_status     = r_status;

    // A compare always follows an issued table read
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_idx != '0) && $past(i_cmd.search_step))
        else $error("table compare without a read");

    // The search never runs past the entry count
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.search_step && $past(i_cmd.search_step)) |-> (r_idx <= limit))
        else $error("search index beyond entry count");

endmodule

// File: hw/rtl/nand_bad_block_remap.sv
`timescale 1ns / 1ps

// NAND bad-block remap. Raise start for one cycle while busy is low to
// transfer an item; each item gives exactly one result, held on the result
// ports for the single cycle in which o_strobe is high, and the receiver
// cannot stall it. A bitmap or substitution write (and the unused operation
// code) answers in the next cycle and busy stays low. A query answers with
// ST_RANGE when the virtual block is out of range, returns the address as it
// is when the address passes through, and otherwise searches the
// substitution table for up to sub_count entries (sub_count capped at
// SUB_ENTRIES): the table RAM is read one entry per cycle with a registered
// read, and the search ends on the first match or when the entries run out.
// The bitmap needs no clearing pass: bytes not written since reset read as
// no block bad. Write ce_count and sub_count only while busy is low and no
// result is pending.
module nand_bad_block_remap #(
    parameter int SUB_ENTRIES  = 64,
    parameter int BITMAP_BYTES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [nbbr_pkg::CHIP_W-1:0]   i_chip,
    input  logic [nbbr_pkg::BLOCK_W-1:0]  i_block,
    input  logic                          i_pool_partition,
    input  logic [nbbr_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [7:0]                    i_bitmap_byte,
    input  logic [nbbr_pkg::LOC_W-1:0]    i_original_vblock,
    input  logic [nbbr_pkg::LOC_W-1:0]    i_spare_location,
    output logic                          o_strobe,
    output logic [nbbr_pkg::CHIP_W-1:0]   o_real_chip,
    output logic [nbbr_pkg::BLOCK_W-1:0]  o_real_block,
    output logic [nbbr_pkg::STAT_W-1:0]   o_status
);

    nbbr_pkg::t_cmd cmd;
    nbbr_pkg::t_sts sts;

    nbbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_operation(i_operation),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy),
        .o_strobe   (o_strobe)
    );

    nbbr_dp #(
        .SUB_ENTRIES (SUB_ENTRIES),
        .BITMAP_BYTES(BITMAP_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_chip           (i_chip),
        .i_block          (i_block),
        .i_pool_partition (i_pool_partition),
        .i_entry_index    (i_entry_index),
        .i_bitmap_byte    (i_bitmap_byte),
        .i_original_vblock(i_original_vblock),
        .i_spare_location (i_spare_location),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_real_chip      (o_real_chip),
        .o_real_block     (o_real_block),
        .o_status         (o_status)
    );

endmodule
